/* rtl/core/tac_pkg.sv */
// shared types, constants and lookup functions for the calibrated tilt angle pipeline
`timescale 1ns / 1ps
`default_nettype none

package tac_pkg;

	// rotation stages actually built, capped by the arctangent table length
	localparam int CORDIC_STAGES = 16;
	localparam int ATAN_LEN      = 24;
	localparam int CORDIC_N      = (CORDIC_STAGES > ATAN_LEN) ? ATAN_LEN : CORDIC_STAGES;

	localparam int CORDIC_W = 27;   // x/y datapath, inputs scaled by 2^8 plus gain
	localparam int ACC_W    = 26;   // angle accumulator, q16 degrees
	localparam int RAW_W    = 19;   // raw tilt, q8 degrees
	localparam int OFF_W    = 15;

	localparam logic signed [ACC_W-1:0] ACC_QUARTER = 26'sd5898240;   // 90 degrees q16
	localparam logic signed [ACC_W-1:0] ACC_HALF_LSB = 26'sd128;

	localparam logic signed [RAW_W-1:0] QUARTER_Q8   = 19'sd23040;
	localparam logic signed [RAW_W-1:0] HALF_TURN_Q8 = 19'sd46080;
	localparam logic signed [RAW_W-1:0] BRK1 = 19'sd10394;
	localparam logic signed [RAW_W-1:0] BRK2 = 19'sd17280;
	localparam logic signed [RAW_W-1:0] BRK3 = 19'sd23040;
	localparam logic signed [RAW_W-1:0] BRK4 = 19'sd28621;
	localparam logic signed [RAW_W-1:0] BRK5 = 19'sd35712;

	localparam logic signed [OFF_W-1:0] OFFSET_MAX = 15'sd11520;
	localparam logic signed [OFF_W-1:0] OFFSET_MIN = -15'sd11520;

	// quotient bias so the reciprocal divide only sees non-negative dividends
	localparam int QBIAS_LOG = 16;

	typedef logic [2:0] seg_t;

	typedef struct packed {
		logic signed [15:0] accel_x;
		logic signed [15:0] accel_z;
	} accel_req_t;

	typedef struct packed {
		logic signed [16:0] angle;
		logic               out_of_range;
	} angle_rsp_t;

	typedef struct packed {
		logic signed [CORDIC_W-1:0] cx;
		logic signed [CORDIC_W-1:0] cy;
		logic signed [ACC_W-1:0]    acc;
		logic                       zero;
	} cordic_t;

	// atan(2^-i) in q16 degrees
	function automatic logic signed [ACC_W-1:0] atan_q16(int i);
		logic signed [ACC_W-1:0] v;
		case (i)
			0:  v = 26'sd2949120;
			1:  v = 26'sd1740967;
			2:  v = 26'sd919879;
			3:  v = 26'sd466945;
			4:  v = 26'sd234379;
			5:  v = 26'sd117304;
			6:  v = 26'sd58666;
			7:  v = 26'sd29335;
			8:  v = 26'sd14668;
			9:  v = 26'sd7334;
			10: v = 26'sd3667;
			11: v = 26'sd1833;
			12: v = 26'sd917;
			13: v = 26'sd458;
			14: v = 26'sd229;
			15: v = 26'sd115;
			16: v = 26'sd57;
			17: v = 26'sd29;
			18: v = 26'sd14;
			19: v = 26'sd7;
			20: v = 26'sd4;
			21: v = 26'sd2;
			22: v = 26'sd1;
			default: v = '0;
		endcase
		return v;
	endfunction

	// segment start on the input axis
	function automatic logic [15:0] seg_ib0(seg_t s);
		logic [15:0] v;
		case (s)
			3'd0: v = 16'd0;
			3'd1: v = 16'd10394;
			3'd2: v = 16'd17280;
			3'd3: v = 16'd23040;
			3'd4: v = 16'd28621;
			3'd5: v = 16'd35712;
			default: v = 16'd0;
		endcase
		return v;
	endfunction

	// segment width on the input axis
	function automatic logic [13:0] seg_den(seg_t s);
		logic [13:0] v;
		case (s)
			3'd0: v = 14'd10394;
			3'd1: v = 14'd6886;
			3'd2: v = 14'd5760;
			3'd3: v = 14'd5581;
			3'd4: v = 14'd7091;
			3'd5: v = 14'd10368;
			default: v = 14'd10394;
		endcase
		return v;
	endfunction

	// segment rise on the output axis
	function automatic logic [13:0] seg_dob(seg_t s);
		logic [13:0] v;
		case (s)
			3'd0: v = 14'd11520;
			3'd1: v = 14'd6400;
			3'd2: v = 14'd5120;
			3'd3: v = 14'd5120;
			3'd4: v = 14'd6400;
			3'd5: v = 14'd11520;
			default: v = 14'd11520;
		endcase
		return v;
	endfunction

	// segment start on the output axis
	function automatic logic [15:0] seg_ob0(seg_t s);
		logic [15:0] v;
		case (s)
			3'd0: v = 16'd0;
			3'd1: v = 16'd11520;
			3'd2: v = 16'd17920;
			3'd3: v = 16'd23040;
			3'd4: v = 16'd28160;
			3'd5: v = 16'd34560;
			default: v = 16'd0;
		endcase
		return v;
	endfunction

	// floor(2^32 / (2 * width)), estimate is low by at most one
	function automatic logic [18:0] seg_recip(seg_t s);
		logic [18:0] v;
		case (s)
			3'd0: v = 19'd206608;
			3'd1: v = 19'd311862;
			3'd2: v = 19'd372827;
			3'd3: v = 19'd384784;
			3'd4: v = 19'd302846;
			3'd5: v = 19'd207126;
			default: v = 19'd206608;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

/* rtl/core/tilt_angle_calibrated.sv */
// calibrated tilt angle pipeline: cordic atan2, offset, piecewise-linear remap
// Takes one (accel_x, accel_z) request per cycle and returns the calibrated tilt in signed
// q8 degrees, computed as 90 - atan2(x, z) + offset and remapped through six linear
// segments; a raw tilt of 180 degrees or more returns 0 with out_of_range set. The pipeline
// has one pre-rotation stage, one stage per cordic rotation, then seven stages for rounding,
// segment lookup, the slope multiply and a reciprocal divide with a one-step correction.
// Throughput is one request per cycle while results are not stalled; each stage holds only
// while it is full and the stage after it is held, so empty slots are squeezed out behind a
// stalled result. The offset register saturates to +/-45 degrees on write and should only be
// written while the pipeline is empty.
`timescale 1ns / 1ps
`default_nettype none

module tilt_angle_calibrated (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                sample_valid,
	output      logic                sample_stall,
	input  wire tac_pkg::accel_req_t sample,
	output      logic                result_valid,
	input  wire logic                result_stall,
	output      tac_pkg::angle_rsp_t result,
	input  wire logic                cfg_valid,
	output      logic                cfg_ready,
	input  wire logic signed [14:0]  cfg_data
);

	localparam int N  = tac_pkg::CORDIC_N;
	localparam int CW = tac_pkg::CORDIC_W;
	localparam int AW = tac_pkg::ACC_W;
	localparam int RW = tac_pkg::RAW_W;

	logic signed [14:0] off_q;

	// offset register, saturated on write
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_data > tac_pkg::OFFSET_MAX) begin
				off_q <= tac_pkg::OFFSET_MAX;
			end else if (cfg_data < tac_pkg::OFFSET_MIN) begin
				off_q <= tac_pkg::OFFSET_MIN;
			end else begin
				off_q <= cfg_data;
			end
		end
	end

	// stage valids and enables
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;
	logic en_s1, en_s2, en_s3, en_s4, en_s5, en_s6, en_s7, en_s8;
	logic cord_v_s [N];
	logic cord_en  [N];
	tac_pkg::cordic_t cord_s [N];

	assign en_s8 = !v_s8 || !result_stall;
	assign en_s7 = !v_s7 || en_s8;
	assign en_s6 = !v_s6 || en_s7;
	assign en_s5 = !v_s5 || en_s6;
	assign en_s4 = !v_s4 || en_s5;
	assign en_s3 = !v_s3 || en_s4;
	assign en_s2 = !v_s2 || en_s3;
	assign en_s1 = !v_s1 || cord_en[0];
	assign sample_stall = !en_s1;

	// stage 1: scale and fold the left half plane into the right one
	tac_pkg::cordic_t pre_c;
	tac_pkg::cordic_t pre_s1;
	logic signed [CW-1:0] sx, sz;

	always_comb begin
		sz = {{(CW-24){sample.accel_z[15]}}, sample.accel_z, 8'b0};
		sx = {{(CW-24){sample.accel_x[15]}}, sample.accel_x, 8'b0};
		pre_c.zero = (sample.accel_x == '0) && (sample.accel_z == '0);
		pre_c.cx   = sz;
		pre_c.cy   = sx;
		pre_c.acc  = '0;
		if (sz < 0) begin
			if (sx >= 0) begin
				pre_c.acc = tac_pkg::ACC_QUARTER;
				pre_c.cx  = sx;
				pre_c.cy  = -sz;
			end else begin
				pre_c.acc = -tac_pkg::ACC_QUARTER;
				pre_c.cx  = -sx;
				pre_c.cy  = sz;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en_s1) begin
			v_s1 <= sample_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			pre_s1 <= pre_c;
		end
	end

	// rotation stages, one per pipeline register
	for (genvar i = 0; i < N; i++) begin : g_cordic
		tac_pkg::cordic_t cin;
		tac_pkg::cordic_t cout;
		logic vin;
		logic signed [CW-1:0] dx, dy;

		if (i == 0) begin : g_first
			assign cin = pre_s1;
			assign vin = v_s1;
		end else begin : g_next
			assign cin = cord_s[i-1];
			assign vin = cord_v_s[i-1];
		end

		if (i == N - 1) begin : g_last
			assign cord_en[i] = !cord_v_s[i] || en_s2;
		end else begin : g_mid
			assign cord_en[i] = !cord_v_s[i] || cord_en[i+1];
		end

		always_comb begin
			dx = cin.cy >>> i;
			dy = cin.cx >>> i;
			cout.zero = cin.zero;
			if (!cin.cy[CW-1]) begin
				cout.cx  = cin.cx + dx;
				cout.cy  = cin.cy - dy;
				cout.acc = cin.acc + tac_pkg::atan_q16(i);
			end else begin
				cout.cx  = cin.cx - dx;
				cout.cy  = cin.cy + dy;
				cout.acc = cin.acc - tac_pkg::atan_q16(i);
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				cord_v_s[i] <= 1'b0;
			end else if (cord_en[i]) begin
				cord_v_s[i] <= vin;
			end
		end

		always_ff @(posedge clk) begin
			if (cord_en[i]) begin
				cord_s[i] <= cout;
			end
		end
	end

	// stage 2: round to q8 and form the raw tilt
	logic signed [AW-1:0] acc_rnd;
	logic signed [AW-9:0] a8;
	logic signed [RW-1:0] raw_c, raw_s2;

	always_comb begin
		acc_rnd = cord_s[N-1].acc + tac_pkg::ACC_HALF_LSB;
		a8      = cord_s[N-1].zero ? '0 : acc_rnd[AW-1:8];
		raw_c   = tac_pkg::QUARTER_Q8 - {{(RW-AW+8){a8[AW-9]}}, a8}
		        + {{(RW-15){off_q[14]}}, off_q};
	end

	// stage 3: segment search
	tac_pkg::seg_t seg_c;
	tac_pkg::seg_t seg_s3, seg_s4, seg_s5, seg_s6, seg_s7;
	logic oor_s3, oor_s4, oor_s5, oor_s6, oor_s7;
	logic signed [RW-1:0] t_s3;

	always_comb begin
		if (raw_s2 >= tac_pkg::BRK5) begin
			seg_c = 3'd5;
		end else if (raw_s2 >= tac_pkg::BRK4) begin
			seg_c = 3'd4;
		end else if (raw_s2 >= tac_pkg::BRK3) begin
			seg_c = 3'd3;
		end else if (raw_s2 >= tac_pkg::BRK2) begin
			seg_c = 3'd2;
		end else if (raw_s2 >= tac_pkg::BRK1) begin
			seg_c = 3'd1;
		end else begin
			seg_c = 3'd0;
		end
	end

	// stage 4: slope multiply
	logic signed [34:0] num_c;
	logic signed [31:0] num_s4;

	assign num_c = t_s3 * $signed({2'b0, tac_pkg::seg_dob(seg_s3)});

	// stage 5: rounded, biased dividend 2*num + den + 2^16 * 2*den
	logic [32:0] np_c;
	logic [31:0] np_s5, np_s6, np_s7;
	logic [13:0] den5;

	always_comb begin
		den5 = tac_pkg::seg_den(seg_s4);
		np_c = {num_s4[31], num_s4} + {num_s4[31], num_s4} + {19'b0, den5}
		     + ({19'b0, den5} << (tac_pkg::QBIAS_LOG + 1));
	end

	// stage 6: reciprocal multiply, quotient estimate
	logic [50:0] prod_c;
	logic [17:0] qe_s6, qe_s7;

	assign prod_c = np_s5 * tac_pkg::seg_recip(seg_s5);

	// stage 7: back-multiply the estimate
	logic [14:0] d7;
	logic [32:0] qd_c;
	logic [31:0] qd_s7;

	assign d7   = {tac_pkg::seg_den(seg_s6), 1'b0};
	assign qd_c = qe_s6 * d7;

	// stage 8: correct by one, remove the bias, add the segment base
	logic [14:0] d8;
	logic [31:0] rem_c;
	logic        inc_c;
	logic [19:0] ang_c;
	tac_pkg::angle_rsp_t rsp_c;

	always_comb begin
		d8    = {tac_pkg::seg_den(seg_s7), 1'b0};
		rem_c = np_s7 - qd_s7;
		inc_c = rem_c >= {17'b0, d8};
		ang_c = {2'b0, qe_s7} + {19'b0, inc_c} + {4'b0, tac_pkg::seg_ob0(seg_s7)}
		      - (20'd1 << tac_pkg::QBIAS_LOG);
		rsp_c.out_of_range = oor_s7;
		rsp_c.angle        = oor_s7 ? '0 : ang_c[16:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else begin
			if (en_s2) v_s2 <= cord_v_s[N-1];
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
			if (en_s5) v_s5 <= v_s4;
			if (en_s6) v_s6 <= v_s5;
			if (en_s7) v_s7 <= v_s6;
			if (en_s8) v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			raw_s2 <= raw_c;
		end
		if (en_s3) begin
			seg_s3 <= seg_c;
			oor_s3 <= raw_s2 >= tac_pkg::HALF_TURN_Q8;
			t_s3   <= raw_s2 - $signed({3'b0, tac_pkg::seg_ib0(seg_c)});
		end
		if (en_s4) begin
			seg_s4 <= seg_s3;
			oor_s4 <= oor_s3;
			num_s4 <= num_c[31:0];
		end
		if (en_s5) begin
			seg_s5 <= seg_s4;
			oor_s5 <= oor_s4;
			np_s5  <= np_c[31:0];
		end
		if (en_s6) begin
			seg_s6 <= seg_s5;
			oor_s6 <= oor_s5;
			np_s6  <= np_s5;
			qe_s6  <= prod_c[49:32];
		end
		if (en_s7) begin
			seg_s7 <= seg_s6;
			oor_s7 <= oor_s6;
			np_s7  <= np_s6;
			qe_s7  <= qe_s6;
			qd_s7  <= qd_c[31:0];
		end
		if (en_s8) begin
			result <= rsp_c;
		end
	end

	assign result_valid = v_s8;

endmodule

`default_nettype wire

/* rtl/core/tac_checker.sv */
// port-level checks for the calibrated tilt angle block, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module tac_checker (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                sample_stall,
	input wire logic                result_valid,
	input wire logic                result_stall,
	input wire tac_pkg::angle_rsp_t result
);

	// a held result stays put
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("result changed while stalled");

	// requests are only pushed back when the whole pipe is full behind a held result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		sample_stall |-> result_valid && result_stall)
		else $error("request stalled with room in the pipeline");

	// forced zero on out of range
	a_oor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.out_of_range |-> result.angle == 17'sd0)
		else $error("out of range result with nonzero angle");

	// calibrated angle stays inside the remap span
	a_angle_span: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.angle >= -17'sd38400 && result.angle <= 17'sd46080)
		else $error("angle outside calibrated span");

endmodule

bind tilt_angle_calibrated tac_checker u_tac_checker (.*);

`default_nettype wire
